/* src/vptw_pkg.sv */
// ============================================================================
// vptw_pkg: shared types and constants for the vertex projection unit
// Item layouts for both channels, operation codes and the default fraction
// width of the fixed-point format.
// ============================================================================
package vptw_pkg;

    // Default fraction width of the signed Q format
    localparam int FRAC_BITS_DEF = 16;

    // Operation codes carried in the func field
    localparam logic [1:0] FUNC_LOAD_MV   = 2'd0;
    localparam logic [1:0] FUNC_LOAD_PROJ = 2'd1;
    localparam logic [1:0] FUNC_LOAD_VP   = 2'd2;
    localparam logic [1:0] FUNC_PROJECT   = 2'd3;

    // Input item
    typedef struct packed {
        logic [1:0]          func;
        logic [3:0]          word_index;
        logic signed [31:0]  load_value;
        logic signed [31:0]  obj_x;
        logic signed [31:0]  obj_y;
        logic signed [31:0]  obj_z;
    } vptw_in_t;

    // Result item
    typedef struct packed {
        logic signed [31:0]  win_x;
        logic signed [31:0]  win_y;
        logic signed [31:0]  win_z;
        logic                ok;
    } vptw_out_t;

    // Control carried down the pipeline with every item
    typedef struct packed {
        logic [1:0]          func;
        logic [3:0]          word_index;
        logic signed [31:0]  load_value;
    } vptw_ctl_t;

endpackage

/* src/vertex_project_to_window_unit.sv */
// ============================================================================
// vertex_project_to_window_unit: object-to-window vertex projection
// Modelview and projection transforms, perspective divide and viewport
// mapping in signed fixed point, one item per clock while out_ready is high.
// ============================================================================
//
// Usage:
//   in channel (in_valid/in_ready/in_data) takes load items and project
//   items. A load item writes one word of the modelview matrix, the
//   projection matrix or the viewport and yields no result. A project item
//   yields one result on the out channel (out_valid/out_ready/out_data).
//   Loads and projects keep their order: a load takes effect for every
//   project item accepted after it.
//   Pipeline: four transform stages, one divider setup stage, a restoring
//   divider with one quotient bit per stage (FRAC_BITS + 32 stages) for the
//   three lanes, then ndc, viewport and output stages.
//   Throughput: one item per cycle while the receiver takes results.
//   Reset clears all matrices and the viewport to zero and empties the
//   pipeline. When the receiver stalls, a stage holds only while it is full
//   and the one after it holds, so bubbles close up and input is taken
//   until the pipeline is full.
//
module vertex_project_to_window_unit #(
    parameter int FRAC_BITS = vptw_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vptw_pkg::vptw_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vptw_pkg::vptw_out_t out_data
);

    // Dividend width: |num| << FRAC_BITS plus half the divisor
    localparam int DW = 32 + FRAC_BITS;

    localparam logic signed [65:0] S66_MAX  = 66'sd2147483647;
    localparam logic signed [65:0] S66_MIN  = -S66_MAX - 66'sd1;
    localparam logic signed [65:0] HALF66   = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [51:0] S52_MAX  = 52'sd2147483647;
    localparam logic signed [51:0] S52_MIN  = -S52_MAX - 52'sd1;
    localparam logic signed [32:0] ONE33    = 33'sd1 <<< FRAC_BITS;
    localparam logic signed [33:0] ONE34    = 34'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] S32_MAX  = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN  = 32'sh80000000;

    typedef struct packed {
        logic [DW-1:0] num;
        logic [31:0]   rem;
        logic [31:0]   quo;
        logic          ovf;
        logic          neg;
    } lane_t;

    typedef struct packed {
        vptw_pkg::vptw_ctl_t ctl;
        logic                zero;
        logic [31:0]         den;
        lane_t [2:0]         lane;
    } dstage_t;

    // Dot product row: round to nearest (ties up) at FRAC_BITS, saturate
    function automatic logic signed [31:0] row_round(
        input logic signed [63:0] p0,
        input logic signed [63:0] p1,
        input logic signed [63:0] p2,
        input logic signed [63:0] p3
    );
        logic signed [65:0] s;
        logic signed [65:0] t;
        s = 66'(p0) + 66'(p1) + 66'(p2) + 66'(p3) + HALF66;
        t = s >>> FRAC_BITS;
        if (t > S66_MAX)
            return S32_MAX;
        else if (t < S66_MIN)
            return S32_MIN;
        else
            return t[31:0];
    endfunction

    function automatic logic signed [31:0] sat52(input logic signed [51:0] v);
        if (v > S52_MAX)
            return S32_MAX;
        else if (v < S52_MIN)
            return S32_MIN;
        else
            return v[31:0];
    endfunction

    // ------------------------------------------------------------------
    // State and pipeline registers
    // ------------------------------------------------------------------
    logic signed [31:0]  mv_reg   [16];
    logic signed [31:0]  proj_reg [16];
    logic signed [15:0]  vp_reg   [4];

    logic                v1_reg, v2_reg, v3_reg, v4_reg, v6_reg, v7_reg, v8_reg;
    logic [DW:0]         dsv_reg;

    vptw_pkg::vptw_ctl_t s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg, s6_ctl_reg;
    logic signed [63:0]  s1_prod_reg [16];
    logic signed [63:0]  s1_prod_next [16];
    logic signed [31:0]  s2_eye_reg  [4];
    logic signed [63:0]  s3_prod_reg [16];
    logic signed [63:0]  s3_prod_next [16];
    logic signed [31:0]  s4_clip_reg [4];
    dstage_t             ds_reg  [DW+1];
    dstage_t             ds_next [DW+1];
    logic                s6_zero_reg;
    logic signed [31:0]  s6_ndc_reg  [3];
    logic signed [31:0]  s6_ndc_next [3];
    logic                s7_proj_reg;
    logic                s7_zero_reg;
    logic signed [48:0]  s7_tx_reg, s7_ty_reg;
    logic signed [15:0]  s7_ox_reg, s7_oy_reg;
    logic signed [33:0]  s7_zs_reg;
    vptw_pkg::vptw_out_t s8_out_reg, s8_out_next;

    // Stage enables: a stage loads when it is empty or its successor moves
    logic                en1, en2, en3, en4, en6, en7, en8;
    logic [DW:0]         ds_en;

    assign en8 = !v8_reg || out_ready;
    assign en7 = !v7_reg || en8;
    assign en6 = !v6_reg || en7;
    assign ds_en[DW] = !dsv_reg[DW] || en6;
    for (genvar k = 0; k < DW; k++) begin : g_en
        assign ds_en[k] = !dsv_reg[k] || ds_en[k+1];
    end
    assign en4 = !v4_reg || ds_en[0];
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign in_ready  = en1;
    assign out_valid = v8_reg;
    assign out_data  = s8_out_reg;

    // ------------------------------------------------------------------
    // Valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            dsv_reg <= '0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (ds_en[0]) dsv_reg[0] <= v4_reg;
            for (int k = 1; k <= DW; k++)
            begin
                if (ds_en[k]) dsv_reg[k] <= dsv_reg[k-1];
            end
            if (en6) v6_reg <= dsv_reg[DW];
            if (en7) v7_reg <= v6_reg;
            // only project items reach the output register
            if (en8) v8_reg <= v7_reg && s7_proj_reg;
        end
    end

    // ------------------------------------------------------------------
    // Matrix and viewport state; each is written where it is read
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                mv_reg[i]   <= '0;
                proj_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                vp_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_valid && en1 && in_data.func == vptw_pkg::FUNC_LOAD_MV)
                mv_reg[in_data.word_index] <= in_data.load_value;
            if (v2_reg && en3 && s2_ctl_reg.func == vptw_pkg::FUNC_LOAD_PROJ)
                proj_reg[s2_ctl_reg.word_index] <= s2_ctl_reg.load_value;
            if (v6_reg && en7 && s6_ctl_reg.func == vptw_pkg::FUNC_LOAD_VP
                && s6_ctl_reg.word_index[3:2] == 2'b00)
                vp_reg[s6_ctl_reg.word_index[1:0]] <= s6_ctl_reg.load_value[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: modelview products (w column is a plain shift)
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            s1_prod_next[r]     = 64'(mv_reg[r]) * 64'(in_data.obj_x);
            s1_prod_next[4+r]   = 64'(mv_reg[4+r]) * 64'(in_data.obj_y);
            s1_prod_next[8+r]   = 64'(mv_reg[8+r]) * 64'(in_data.obj_z);
            s1_prod_next[12+r]  = 64'(mv_reg[12+r]) <<< FRAC_BITS;
        end
    end

    // Stage 3: projection products
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                s3_prod_next[c*4+r] = 64'(proj_reg[c*4+r]) * 64'(s2_eye_reg[c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_ctl_reg <= '{func: in_data.func, word_index: in_data.word_index,
                            load_value: in_data.load_value};
            s1_prod_reg <= s1_prod_next;
        end
        // Stage 2: eye vector
        if (en2)
        begin
            s2_ctl_reg <= s1_ctl_reg;
            for (int r = 0; r < 4; r++)
            begin
                s2_eye_reg[r] <= row_round(s1_prod_reg[r], s1_prod_reg[4+r],
                                           s1_prod_reg[8+r], s1_prod_reg[12+r]);
            end
        end
        if (en3)
        begin
            s3_ctl_reg  <= s2_ctl_reg;
            s3_prod_reg <= s3_prod_next;
        end
        // Stage 4: clip vector
        if (en4)
        begin
            s4_ctl_reg <= s3_ctl_reg;
            for (int r = 0; r < 4; r++)
            begin
                s4_clip_reg[r] <= row_round(s3_prod_reg[r], s3_prod_reg[4+r],
                                            s3_prod_reg[8+r], s3_prod_reg[12+r]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider setup: magnitudes, scaled dividend plus half divisor
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [31:0] nabs;
        logic [31:0] dabs;
        dabs = s4_clip_reg[3][31] ? 32'(-s4_clip_reg[3]) : s4_clip_reg[3];
        ds_next[0].ctl  = s4_ctl_reg;
        ds_next[0].zero = (s4_clip_reg[3] == '0);
        ds_next[0].den  = dabs;
        for (int i = 0; i < 3; i++)
        begin
            nabs = s4_clip_reg[i][31] ? 32'(-s4_clip_reg[i]) : s4_clip_reg[i];
            ds_next[0].lane[i].num = (DW'(nabs) << FRAC_BITS) + DW'(dabs >> 1);
            ds_next[0].lane[i].rem = '0;
            ds_next[0].lane[i].quo = '0;
            ds_next[0].lane[i].ovf = 1'b0;
            ds_next[0].lane[i].neg = s4_clip_reg[i][31] ^ s4_clip_reg[3][31];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ds_en[0])
            ds_reg[0] <= ds_next[0];
    end

    // Restoring divider, one quotient bit per stage, three lanes
    for (genvar k = 1; k <= DW; k++) begin : g_div
        always_comb
        begin
            logic [32:0] trial;
            logic [32:0] diff;
            ds_next[k] = ds_reg[k-1];
            for (int i = 0; i < 3; i++)
            begin
                trial = {ds_reg[k-1].lane[i].rem, ds_reg[k-1].lane[i].num[DW-k]};
                diff  = trial - {1'b0, ds_reg[k-1].den};
                ds_next[k].lane[i].rem = diff[32] ? trial[31:0] : diff[31:0];
                ds_next[k].lane[i].quo = {ds_reg[k-1].lane[i].quo[30:0], !diff[32]};
                ds_next[k].lane[i].ovf = ds_reg[k-1].lane[i].ovf
                                         | ds_reg[k-1].lane[i].quo[31];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ds_en[k])
                ds_reg[k] <= ds_next[k];
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: signed, saturated ndc
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (ds_reg[DW].lane[i].neg)
            begin
                if (ds_reg[DW].lane[i].ovf || ds_reg[DW].lane[i].quo > 32'h80000000)
                    s6_ndc_next[i] = S32_MIN;
                else
                    s6_ndc_next[i] = 32'(-ds_reg[DW].lane[i].quo);
            end
            else
            begin
                if (ds_reg[DW].lane[i].ovf || ds_reg[DW].lane[i].quo[31])
                    s6_ndc_next[i] = S32_MAX;
                else
                    s6_ndc_next[i] = ds_reg[DW].lane[i].quo;
            end
        end
    end

    // Result assembly
    always_comb
    begin
        logic signed [51:0] wx;
        logic signed [51:0] wy;
        wx = (52'(s7_ox_reg) <<< FRAC_BITS) + 52'((s7_tx_reg + 49'sd1) >>> 1);
        wy = (52'(s7_oy_reg) <<< FRAC_BITS) + 52'((s7_ty_reg + 49'sd1) >>> 1);
        if (s7_zero_reg)
        begin
            s8_out_next = '0;
        end
        else
        begin
            s8_out_next.win_x = sat52(wx);
            s8_out_next.win_y = sat52(wy);
            s8_out_next.win_z = sat52(52'(s7_zs_reg >>> 1));
            s8_out_next.ok    = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            s6_ctl_reg  <= ds_reg[DW].ctl;
            s6_zero_reg <= ds_reg[DW].zero;
            s6_ndc_reg  <= s6_ndc_next;
        end
        // Stage 7: viewport scaling
        if (en7)
        begin
            s7_proj_reg <= (s6_ctl_reg.func == vptw_pkg::FUNC_PROJECT);
            s7_zero_reg <= s6_zero_reg;
            s7_tx_reg   <= 49'(33'(s6_ndc_reg[0]) + ONE33) * 49'(vp_reg[2]);
            s7_ty_reg   <= 49'(33'(s6_ndc_reg[1]) + ONE33) * 49'(vp_reg[3]);
            s7_ox_reg   <= vp_reg[0];
            s7_oy_reg   <= vp_reg[1];
            s7_zs_reg   <= 34'(s6_ndc_reg[2]) + ONE34 + 34'sd1;
        end
        // Stage 8: output register
        if (en8)
            s8_out_reg <= s8_out_next;
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_top: testbench for vertex_project_to_window_unit
// Loads matrices and viewports, projects points and compares every result
// against an in-bench fixed-point projection computed at item acceptance.
// ============================================================================
module tb_top;

    localparam int F = vptw_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = F + 40;
    localparam longint CYCLE_LIMIT = 2000000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    vptw_pkg::vptw_in_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    vptw_pkg::vptw_out_t out_data;

    // shadow of the block's matrices and viewport, zero like the block at reset
    logic [31:0] mv_shadow [16] = '{default: '0};
    logic [31:0] pj_shadow [16] = '{default: '0};
    logic [15:0] vp_shadow [4] = '{default: '0};

    vptw_pkg::vptw_out_t window_q [$];
    int         fail_count = 0;
    longint     cycle_count = 0;
    int         hold_cycles = 0;
    bit         hold_on = 1'b0;
    int         recv_gap_max = 3;

    vertex_project_to_window_unit uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data)
    );

    always #5 clk = ~clk;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // one row of a column-major matrix times a vector, rounded half up
    function automatic longint row_dot(logic [31:0] m [16], int row, longint v [4]);
        longint hi, lo, p;
        hi = 0;
        lo = 0;
        for (int c = 0; c < 4; c++)
        begin
            p = longint'($signed(m[c * 4 + row])) * v[c];
            hi += p >>> F;
            lo += p & ((64'sd1 <<< F) - 1);
        end
        lo += 64'sd1 <<< (F - 1);
        return sat32(hi + (lo >>> F));
    endfunction

    // perspective divide on magnitudes, ties away from zero
    function automatic longint ndc_divide(longint num, longint den);
        bit neg;
        logic [63:0] n, d, q;
        neg = (num < 0) != (den < 0);
        n = (num < 0 ? -num : num) << F;
        d = den < 0 ? -den : den;
        q = (n + d / 2) / d;
        if (neg)
        begin
            if (q > 64'd2147483648) return -64'sd2147483648;
            return -longint'(q);
        end
        if (q > 64'd2147483647) return 64'sd2147483647;
        return longint'(q);
    endfunction

    function automatic longint to_window(longint ndc, longint org, longint size);
        longint t;
        t = ((64'sd1 <<< F) + ndc) * size;
        return sat32(org * (64'sd1 <<< F) + ((t + 1) >>> 1));
    endfunction

    // apply one accepted item; queue the expected window point if it projects
    function automatic void project_vertex(vptw_pkg::vptw_in_t it);
        longint obj [4], eye [4], clp [4];
        vptw_pkg::vptw_out_t r;
        case (it.func)
            vptw_pkg::FUNC_LOAD_MV:
                mv_shadow[it.word_index] = it.load_value;
            vptw_pkg::FUNC_LOAD_PROJ:
                pj_shadow[it.word_index] = it.load_value;
            vptw_pkg::FUNC_LOAD_VP:
                if (it.word_index < 4) vp_shadow[it.word_index[1:0]] = it.load_value[15:0];
            default:
            begin
                obj[0] = longint'(it.obj_x);
                obj[1] = longint'(it.obj_y);
                obj[2] = longint'(it.obj_z);
                obj[3] = 64'sd1 <<< F;
                for (int i = 0; i < 4; i++) eye[i] = row_dot(mv_shadow, i, obj);
                for (int i = 0; i < 4; i++) clp[i] = row_dot(pj_shadow, i, eye);
                r = '0;
                if (clp[3] != 0)
                begin
                    r.win_x = 32'(to_window(ndc_divide(clp[0], clp[3]),
                        longint'($signed(vp_shadow[0])), longint'($signed(vp_shadow[2]))));
                    r.win_y = 32'(to_window(ndc_divide(clp[1], clp[3]),
                        longint'($signed(vp_shadow[1])), longint'($signed(vp_shadow[3]))));
                    r.win_z = 32'(sat32(((64'sd1 <<< F) + ndc_divide(clp[2], clp[3]) + 1)
                                        >>> 1));
                    r.ok = 1'b1;
                end
                window_q.insert(window_q.size(), r);
            end
        endcase
    endfunction

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // expected results follow input acceptance
    always @(posedge clk)
        if (rst_n && in_valid && in_ready) project_vertex(in_data);

    // result check
    always @(posedge clk)
    begin
        vptw_pkg::vptw_out_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (window_q.size() == 0)
            begin
                $error("result with nothing expected");
                fail_count++;
            end
            else
            begin
                e = window_q.pop_front();
                if (out_data.ok !== e.ok)
                begin
                    $error("ok: expected %0d actual %0d", e.ok, out_data.ok);
                    fail_count++;
                end
                if (out_data.win_x !== e.win_x)
                begin
                    $error("win_x: expected %0d actual %0d", e.win_x, out_data.win_x);
                    fail_count++;
                end
                if (out_data.win_y !== e.win_y)
                begin
                    $error("win_y: expected %0d actual %0d", e.win_y, out_data.win_y);
                    fail_count++;
                end
                if (out_data.win_z !== e.win_z)
                begin
                    $error("win_z: expected %0d actual %0d", e.win_z, out_data.win_z);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_on)
            out_ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_ready <= 1'b0;
        end
        else if (out_ready && out_valid)
        begin
            hold_cycles = $urandom_range(recv_gap_max, 0);
            out_ready <= (hold_cycles == 0);
        end
        else
            out_ready <= 1'b1;
    end

    // send one item with a random lead gap; valid stays up for a follower
    task automatic send_item(vptw_pkg::vptw_in_t it, int gap_max = 3);
        int gap;
        gap = $urandom_range(gap_max, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // drop valid after the last item of a sequence
    task automatic stop_input();
        in_valid <= 1'b0;
    endtask

    task automatic send_load(logic [1:0] fn, int idx, logic [31:0] v);
        vptw_pkg::vptw_in_t it;
        it = '0;
        it.func = fn;
        it.word_index = 4'(idx);
        it.load_value = v;
        it.obj_x = $urandom;
        send_item(it);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        vptw_pkg::vptw_in_t it;
        it.func = vptw_pkg::FUNC_PROJECT;
        it.word_index = 4'($urandom);
        it.load_value = $urandom;
        it.obj_x = x;
        it.obj_y = y;
        it.obj_z = z;
        send_item(it);
    endtask

    task automatic drain_results();
        while (window_q.size() != 0) @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    // random Q coefficient, mostly small, sometimes full range
    function automatic logic [31:0] rand_coef();
        case ($urandom_range(3, 0))
            0: return $urandom;
            1: return 32'(int'($urandom_range(4 << F, 0)) - (2 << F));
            default: return 32'(int'($urandom_range(2 << F, 0)) - (1 << F));
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        if ($urandom_range(4, 0) == 0) return $urandom;
        return 32'(int'($urandom_range(200 << F, 0)) - (100 << F));
    endfunction

    task automatic load_identity(logic [1:0] fn);
        for (int i = 0; i < 16; i++)
            send_load(fn, i, (i % 5 == 0) ? (32'd1 << F) : 32'd0);
    endtask

    task automatic load_viewport(int x0, int y0, int w, int h);
        send_load(vptw_pkg::FUNC_LOAD_VP, 0, x0);
        send_load(vptw_pkg::FUNC_LOAD_VP, 1, y0);
        send_load(vptw_pkg::FUNC_LOAD_VP, 2, w);
        send_load(vptw_pkg::FUNC_LOAD_VP, 3, h);
    endtask

    // after reset all matrices are zero: project must fail
    task automatic test_after_reset();
        send_point(32'h7fffffff, 32'h80000000, 32'd0);
        send_point(32'd1 << F, 32'd0, 32'hffffffff);
    endtask

    // identity transforms, viewport extremes, ignored viewport index
    task automatic test_directed();
        load_identity(vptw_pkg::FUNC_LOAD_MV);
        load_identity(vptw_pkg::FUNC_LOAD_PROJ);
        load_viewport(0, 0, 640, 480);
        send_load(vptw_pkg::FUNC_LOAD_VP, 7, 32'h1234);
        send_point(32'd0, 32'd0, 32'd0);
        send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_point(32'h80000000, 32'h7fffffff, 32'h80000000);
        load_viewport(-32768, 32767, 32767, -32768);
        send_point(32'd1 << F, 32'hffff0000, 32'h00008000);
        // zero clip w
        send_load(vptw_pkg::FUNC_LOAD_PROJ, 15, 32'd0);
        send_point(32'd5 << F, 32'd3 << F, 32'd1 << F);
        // extreme coefficients saturating eye and clip
        send_load(vptw_pkg::FUNC_LOAD_PROJ, 15, 32'h80000000);
        send_load(vptw_pkg::FUNC_LOAD_MV, 0, 32'h7fffffff);
        send_point(32'h7fffffff, 32'd1, 32'hffffffff);
    endtask

    // random setups followed by bursts of points, with some loads mixed in
    task automatic test_random(int n_items);
        int sent;
        sent = 0;
        while (sent < n_items)
        begin
            for (int i = 0; i < 16; i++) send_load(vptw_pkg::FUNC_LOAD_MV, i, rand_coef());
            for (int i = 0; i < 16; i++) send_load(vptw_pkg::FUNC_LOAD_PROJ, i, rand_coef());
            for (int i = 0; i < 4; i++)
                send_load(vptw_pkg::FUNC_LOAD_VP, $urandom_range(15, 0), $urandom);
            sent += 36;
            repeat ($urandom_range(60, 20))
            begin
                if ($urandom_range(9, 0) == 0)
                    send_load(2'($urandom_range(2, 0)), $urandom_range(15, 0), $urandom);
                else
                    send_point(rand_coord(), rand_coord(), rand_coord());
                sent++;
            end
        end
    endtask

    // long receiver hold-off so the pipeline fills and stalls the input
    task automatic test_backpressure();
        hold_on = 1'b1;
        fork
            begin
                repeat (LATENCY * 3) send_point(rand_coord(), rand_coord(), rand_coord());
                stop_input();
            end
            repeat (LATENCY * 4) @(negedge clk);
        join_any
        hold_on = 1'b0;
        wait fork;
    endtask

    // back-to-back streaming with no gaps on either side
    task automatic test_streaming();
        vptw_pkg::vptw_in_t it;
        recv_gap_max = 0;
        repeat (200)
        begin
            it = '0;
            it.func = vptw_pkg::FUNC_PROJECT;
            it.obj_x = rand_coord();
            it.obj_y = rand_coord();
            it.obj_z = rand_coord();
            send_item(it, 0);
        end
        recv_gap_max = 3;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_after_reset();
        test_directed();
        stop_input();
        drain_results();
        test_random(1100);
        test_backpressure();
        drain_results();
        test_streaming();
        stop_input();
        drain_results();
        if (fail_count == 0 && window_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* vertex_project_to_window_unit.f */
src/vptw_pkg.sv
src/vertex_project_to_window_unit.sv
tb/tb_top.sv
